// ===== rtl/rhc_pkg.sv =====
// Package for the RGB to HSV converter.
// Holds the field widths, the sector codes, the word that moves down the
// divider chain and the hue scaling constants. No dependencies.
package rhc_pkg;

	// Channel and result widths.
	localparam int CH_W   = 8;
	localparam int HUE_W  = 15;
	localparam int SAT_W  = 16;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 48;

	// Width of the partial remainders and shifted divisors in the chain.
	localparam int REM_W  = 24;

	// One cell resolves one quotient bit, so the chain is as long as the quotient.
	localparam int QUO_W  = SAT_W;
	localparam int NUM_CELLS = QUO_W;

	// Hue magnitude never exceeds one sector, which fits in twelve bits.
	localparam int MAG_W  = 12;

	// Hue scale: 60 degrees is 3840 units of 1/64 degree, a full turn 23040.
	localparam logic [HUE_W-1:0] UNITS_PER_SECTOR = 15'd3840;
	localparam logic [HUE_W-1:0] UNITS_PER_TURN   = 15'd23040;
	localparam logic [HUE_W-1:0] BASE_GREEN       = 15'd7680;
	localparam logic [HUE_W-1:0] BASE_BLUE        = 15'd15360;

	// Sector codes, chosen by which channel is largest.
	localparam logic [1:0] SECTOR_RED   = 2'd0;
	localparam logic [1:0] SECTOR_GREEN = 2'd1;
	localparam logic [1:0] SECTOR_BLUE  = 2'd2;

	// Word handed from cell to cell.
	typedef struct packed {
		logic [REM_W-1:0] sat_rem;
		logic [REM_W-1:0] sat_div;
		logic [QUO_W-1:0] sat_quo;
		logic [REM_W-1:0] hue_rem;
		logic [REM_W-1:0] hue_div;
		logic [QUO_W-1:0] hue_quo;
		logic [CH_W-1:0]  value;
		logic [CH_W-1:0]  opacity;
		logic [1:0]       sector;
		logic             neg;
		logic             grey;
	} cell_word_t;

endpackage

// ===== rtl/rhc_front.sv =====
// Front stage of the RGB to HSV converter: max, min, delta, sector choice
// and the two dividends and divisors that start the divider chain.
// Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cell_word_t       out_word
);

	logic [CH_W-1:0] red, green, blue, alpha;
	logic [CH_W-1:0] hi, lo, delta, plus, minus, diff;
	logic [1:0]      sector;
	logic            valid_q;
	cell_word_t      word_d;
	cell_word_t      word_s1;

	assign red   = in_data[7:0];
	assign green = in_data[15:8];
	assign blue  = in_data[23:16];
	assign alpha = in_data[31:24];

	// Largest and smallest channel.
	always_comb begin
		hi = (red > green) ? red : green;
		if (blue > hi) begin
			hi = blue;
		end
		lo = (red < green) ? red : green;
		if (blue < lo) begin
			lo = blue;
		end
		delta = hi - lo;
	end

	// Sector with red, then green, then blue winning ties.
	always_comb begin
		if (red == hi) begin
			sector = SECTOR_RED;
			plus   = green;
			minus  = blue;
		end else if (green == hi) begin
			sector = SECTOR_GREEN;
			plus   = blue;
			minus  = red;
		end else begin
			sector = SECTOR_BLUE;
			plus   = red;
			minus  = green;
		end
		diff = (plus >= minus) ? (plus - minus) : (minus - plus);
	end

	// Dividends are delta*65535 and diff*3840; divisors start shifted up by
	// one less than the quotient width.
	always_comb begin
		word_d.sat_rem = {delta, 16'b0} - {16'b0, delta};
		word_d.sat_div = {1'b0, hi, {(QUO_W-1){1'b0}}};
		word_d.sat_quo = '0;
		word_d.hue_rem = {4'b0, ({diff, 12'b0} - {4'b0, diff, 8'b0})};
		word_d.hue_div = {1'b0, delta, {(QUO_W-1){1'b0}}};
		word_d.hue_quo = '0;
		word_d.value   = hi;
		word_d.opacity = alpha;
		word_d.sector  = sector;
		word_d.neg     = (plus < minus);
		word_d.grey    = (delta == '0);
	end

	assign in_ready = !valid_q || out_ready;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_s1;

endmodule

// ===== rtl/rhc_div_cell.sv =====
// One cell of the divider chain: resolves one quotient bit of the saturation
// and of the hue division, then hands the word to the next cell.
// Depends on rhc_pkg.
module rhc_div_cell import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_word_t in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_word_t out_word
);

	logic       sat_ge, hue_ge;
	logic       valid_q;
	cell_word_t word_d;
	cell_word_t word_q;

	// Restoring step: subtract the shifted divisor where it fits.
	always_comb begin
		word_d  = in_word;
		sat_ge  = in_word.sat_rem >= in_word.sat_div;
		hue_ge  = in_word.hue_rem >= in_word.hue_div;
		word_d.sat_rem = sat_ge ? (in_word.sat_rem - in_word.sat_div) : in_word.sat_rem;
		word_d.hue_rem = hue_ge ? (in_word.hue_rem - in_word.hue_div) : in_word.hue_rem;
		word_d.sat_div = in_word.sat_div >> 1;
		word_d.hue_div = in_word.hue_div >> 1;
		word_d.sat_quo = {in_word.sat_quo[QUO_W-2:0], sat_ge};
		word_d.hue_quo = {in_word.hue_quo[QUO_W-2:0], hue_ge};
	end

	assign in_ready = !valid_q || out_ready;

	// Cell valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Cell payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ===== rtl/rhc_back.sv =====
// Back stage of the RGB to HSV converter: builds the hue from sector and
// quotient, masks grey pixels and holds the output word.
// Depends on rhc_pkg.
module rhc_back import rhc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cell_word_t       in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic [HUE_W-1:0] base, mag, hue;
	logic [SAT_W-1:0] sat;
	logic             valid_q;
	logic [OUT_W-1:0] data_q;

	// Sector base in hue units.
	always_comb begin
		case (in_word.sector)
			SECTOR_RED:   base = '0;
			SECTOR_GREEN: base = BASE_GREEN;
			SECTOR_BLUE:  base = BASE_BLUE;
			default:      base = '0;
		endcase
	end

	// Hue: base plus or minus the magnitude, a negative result wraps a turn.
	always_comb begin
		mag = {{(HUE_W-MAG_W){1'b0}}, in_word.hue_quo[MAG_W-1:0]};
		if (in_word.grey) begin
			hue = '0;
		end else if (!in_word.neg) begin
			hue = base + mag;
		end else if (base == '0 && mag != '0) begin
			hue = UNITS_PER_TURN - mag;
		end else begin
			hue = base - mag;
		end
		sat = in_word.grey ? '0 : in_word.sat_quo;
	end

	assign in_ready = !valid_q || out_ready;

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= {1'b0, in_word.opacity, in_word.value, sat, hue};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter.
// Connects the front stage, the chain of divider cells and the back stage.
// Depends on rhc_pkg, rhc_front, rhc_div_cell and rhc_back.
//
// The converter takes one RGBA pixel word per clock while the output is ready
// and returns one HSV word per pixel, in order. A pixel passes the front
// register (max, min and sector), the chain of divider cells (one quotient
// bit of saturation and of hue per cell), then the hue assembly into the
// output register. Every stage has its own valid bit and accepts a new word
// whenever it is empty or its contents move on, so the converter sustains
// one word per clock while the output is ready and fills bubbles while the
// output is stalled. Hue is in 1/64 degree (0 to 23039), saturation scaled
// so that 65535 means 1.0, value is the largest channel, opacity is alpha.
module rgb_to_hsv_converter import rhc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // hue[14:0], saturation[30:15], value[38:31],
	                                   // opacity[46:39], zero[47]
);

	logic       chain_valid [NUM_CELLS+1];
	logic       chain_ready [NUM_CELLS+1];
	cell_word_t chain_word  [NUM_CELLS+1];

	// Operand setup.
	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	// Hue assembly and output register.
	rhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[NUM_CELLS]),
		.in_ready  (chain_ready[NUM_CELLS]),
		.in_word   (chain_word[NUM_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ===== rtl/rhc_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter.
module rhc_checker import rhc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A waiting input word stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while waiting");

	// A stalled output word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// Hue stays below one full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:0] < UNITS_PER_TURN)
		else $error("hue out of range");

	// Zero saturation only comes from a grey pixel, whose hue is zero.
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30:15] == '0 |-> m_tdata[14:0] == '0)
		else $error("grey pixel with nonzero hue");

	// A black pixel has no hue and no saturation.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38:31] == '0 |-> m_tdata[30:0] == '0)
		else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/rgb_to_hsv_converter_tb.sv =====
// Testbench for the RGB to HSV converter: directed and random RGBA pixels with
// random idle gaps on both stream sides, each HSV word checked against a predictor.
// Depends on rhc_pkg and rgb_to_hsv_converter.
module rgb_to_hsv_converter_tb;
	import rhc_pkg::*;

	localparam int RANDOM_PIXELS = 850;
	localparam int MODE_SPAN     = 50;
	localparam int MAX_GAP       = 17;
	localparam int DRAIN_CYCLES  = 40;
	localparam int STALL_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;

	// One HSV result word, split into its fields.
	typedef struct packed {
		logic             pad;
		logic [CH_W-1:0]  opacity;
		logic [CH_W-1:0]  value;
		logic [SAT_W-1:0] saturation;
		logic [HUE_W-1:0] hue;
	} hsv_word_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // hue[14:0], saturation[30:15], value[38:31],
	                             // opacity[46:39], zero[47]

	hsv_word_t pending_hsv[$];
	bit        pixel_burst;
	bit        hsv_burst;
	int        pixels_sent;
	int        hsv_checked = 0;
	int        field_mismatches = 0;
	int        orphan_words = 0;
	int        missing_words;
	int        idle_cycles = 0;

	rgb_to_hsv_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Predicts the HSV word for one pixel.
	function automatic hsv_word_t convert_pixel(input logic [CH_W-1:0] r, g, b, a);
		hsv_word_t   px;
		int unsigned hi;
		int unsigned lo;
		int unsigned delta;
		int unsigned plus;
		int unsigned minus;
		int unsigned mag;
		int          base;
		int          h;
		hi = (r > g) ? 32'(r) : 32'(g);
		hi = (hi > 32'(b)) ? hi : 32'(b);
		lo = (r < g) ? 32'(r) : 32'(g);
		lo = (lo < 32'(b)) ? lo : 32'(b);
		delta = hi - lo;
		px = '0;
		px.value = hi[CH_W-1:0];
		px.opacity = a;
		if (delta != 0) begin
			px.saturation = SAT_W'((delta * 65535) / hi);
			// Red wins ties over green, green over blue.
			if (32'(r) == hi) begin
				base = 0;
				plus = 32'(g);
				minus = 32'(b);
			end else if (32'(g) == hi) begin
				base = int'(BASE_GREEN);
				plus = 32'(b);
				minus = 32'(r);
			end else begin
				base = int'(BASE_BLUE);
				plus = 32'(r);
				minus = 32'(g);
			end
			if (plus >= minus) begin
				mag = ((plus - minus) * int'(UNITS_PER_SECTOR)) / delta;
				h = base + int'(mag);
			end else begin
				mag = ((minus - plus) * int'(UNITS_PER_SECTOR)) / delta;
				h = base - int'(mag);
			end
			if (h < 0)
				h += int'(UNITS_PER_TURN);
			px.hue = h[HUE_W-1:0];
		end
		return px;
	endfunction

	// Idle cycles before the next word; zero throughout a burst.
	function automatic int draw_gap(input bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Sends one pixel word and records its expected HSV word once it is taken.
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, a);
		int gap;
		gap = draw_gap(pixel_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {a, b, g, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_hsv.push_back(convert_pixel(r, g, b, a));
		pixels_sent++;
	endtask

	// Black, white, greys and the extremes of every channel and of alpha.
	task automatic test_grey_and_extremes();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128, 8'hAA);
		send_pixel(8'd1, 8'd1, 8'd1, 8'h55);
		send_pixel(8'd1, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254, 8'd0);
		send_pixel(8'hAA, 8'h55, 8'hFF, 8'h0F);
		send_pixel(8'h55, 8'hAA, 8'h00, 8'hF0);
	endtask

	// Each sector from a pure primary, then every kind of tie for the largest channel.
	task automatic test_primaries_and_ties();
		send_pixel(8'd255, 8'd0, 8'd0, 8'd1);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd2);
		send_pixel(8'd0, 8'd0, 8'd255, 8'd3);
		send_pixel(8'd255, 8'd255, 8'd0, 8'd4);
		send_pixel(8'd0, 8'd255, 8'd255, 8'd5);
		send_pixel(8'd255, 8'd0, 8'd255, 8'd6);
		send_pixel(8'd200, 8'd200, 8'd10, 8'd7);
		send_pixel(8'd3, 8'd90, 8'd90, 8'd8);
		send_pixel(8'd77, 8'd20, 8'd77, 8'd9);
	endtask

	// Red with blue over green: hue goes negative and wraps; then one blue pixel.
	task automatic test_hue_wrap();
		send_pixel(8'd255, 8'd0, 8'd1, 8'd10);
		send_pixel(8'd255, 8'd0, 8'd254, 8'd11);
		send_pixel(8'd2, 8'd0, 8'd1, 8'd12);
		send_pixel(8'd100, 8'd37, 8'd99, 8'd13);
		send_pixel(8'd0, 8'd1, 8'd2, 8'd14);
	endtask

	// Random pixels; each span of pixels redraws whether source and sink idle or burst.
	task automatic test_random_pixels();
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
		int              lvl;
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % MODE_SPAN == 0) begin
				pixel_burst = ($urandom_range(0, 2) == 0);
				hsv_burst = ($urandom_range(0, 2) == 0);
			end
			r = CH_W'($urandom);
			g = CH_W'($urandom);
			b = CH_W'($urandom);
			a = CH_W'($urandom);
			case ($urandom_range(0, 5))
				// Near grey: tiny deltas stress the divider.
				3: begin
					lvl = $urandom_range(0, 250);
					r = CH_W'(lvl + $urandom_range(0, 5));
					g = CH_W'(lvl + $urandom_range(0, 5));
					b = CH_W'(lvl + $urandom_range(0, 5));
				end
				// Two channels equal.
				4: begin
					case ($urandom_range(0, 2))
						0: g = r;
						1: b = g;
						default: b = r;
					endcase
				end
				// A channel pinned at an extreme.
				5: begin
					lvl = ($urandom_range(0, 1) == 0) ? 0 : 255;
					case ($urandom_range(0, 2))
						0: r = CH_W'(lvl);
						1: g = CH_W'(lvl);
						default: b = CH_W'(lvl);
					endcase
				end
				default: ;
			endcase
			send_pixel(r, g, b, a);
		end
		pixel_burst = 1'b0;
		hsv_burst = 1'b0;
	endtask

	// Sink side: random stalls before each HSV word.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = draw_gap(hsv_burst);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Compare each HSV word taken with the oldest prediction.
	always @(posedge clk) begin : check_hsv
		hsv_word_t got;
		hsv_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_hsv.size() == 0) begin
				orphan_words++;
				if (orphan_words + field_mismatches <= MAX_REPORTS)
					$display("unexpected HSV word %h", m_tdata);
			end else begin
				want = pending_hsv.pop_front();
				hsv_checked++;
				if (got !== want) begin
					field_mismatches++;
					if (orphan_words + field_mismatches <= MAX_REPORTS)
						$display({"mismatch on word %0d: hue %0d/%0d sat %0d/%0d ",
							"value %0d/%0d opacity %0d/%0d pad %b/%b (expected/actual)"},
							hsv_checked, want.hue, got.hue, want.saturation,
							got.saturation, want.value, got.value, want.opacity,
							got.opacity, want.pad, got.pad);
				end
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("watchdog: no word moved for %0d cycles", idle_cycles);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		pixel_burst = 1'b0;
		hsv_burst = 1'b0;
		pixels_sent = 0;
		missing_words = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_grey_and_extremes();
		test_primaries_and_ties();
		test_hue_wrap();
		test_random_pixels();
		s_tvalid <= 1'b0;

		// Let the pipeline drain, then watch a little longer for stray words.
		while (pending_hsv.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		missing_words = pending_hsv.size();

		$display("Converted %0d pixels (greys, primaries, ties, wrapped hues, random)",
			pixels_sent);
		$display("%0d HSV words checked: %0d mismatches, %0d unexpected, %0d missing",
			hsv_checked, field_mismatches, orphan_words, missing_words);
		if (field_mismatches == 0 && orphan_words == 0 && missing_words == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
